// ===== sv/ptqs_pkg.sv =====
// ----------------------------------------------------------------------------
// ptqs_pkg: shared types for the priority transmit queue scheduler
// Command codes, queue classes, the classified command and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package ptqs_pkg;

	typedef enum logic [1:0] {
		OP_ENQUEUE = 2'd0,
		OP_KICK    = 2'd1,
		OP_CLEAR   = 2'd2,
		OP_NOP     = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		CLS_RESPONSE = 2'd0,
		CLS_CONTROL  = 2'd1,
		CLS_STREAM   = 2'd2,
		CLS_INVALID  = 2'd3
	} cls_t;

	typedef struct packed {
		op_t         op;
		cls_t        cls;
		logic        too_long;
		logic [31:0] handle;
		logic [7:0]  length;
		logic        sink_ready;
	} cmd_t;

	typedef struct packed {
		logic clear;
		logic drop;
		logic push;
		logic pop;
	} ring_ctl_t;

	typedef struct packed {
		logic        status;
		logic        sent_valid;
		logic [1:0]  sent_class;
		logic [31:0] sent_handle;
		logic [7:0]  sent_length;
		logic        stream_dropped;
		logic [3:0]  response_fill;
		logic [3:0]  control_fill;
		logic [3:0]  stream_fill;
	} res_t;

endpackage

`default_nettype wire

// ===== sv/ptqs_front.sv =====
// ----------------------------------------------------------------------------
// ptqs_front: command intake
// Accepts a transaction, decodes it and checks the length limit.
// ----------------------------------------------------------------------------
`default_nettype none

module ptqs_front import ptqs_pkg::*; #(
	parameter int unsigned MAX_MESSAGE_BYTES = 64
) (
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  opcode,
	input  wire logic [1:0]  msg_class,
	input  wire logic [31:0] message_handle,
	input  wire logic [7:0]  message_length,
	input  wire logic        sink_ready,
	input  wire logic        fifo_full,
	output logic             push,
	output cmd_t             cmd
);

	localparam logic [7:0] MAX_LEN = 8'(MAX_MESSAGE_BYTES);

	assign busy = fifo_full;
	assign push = start && !fifo_full;

	always_comb begin
		cmd.op         = op_t'(opcode);
		cmd.cls        = cls_t'(msg_class);
		cmd.too_long   = message_length > MAX_LEN;
		cmd.handle     = message_handle;
		cmd.length     = message_length;
		cmd.sink_ready = sink_ready;
	end

endmodule

`default_nettype wire

// ===== sv/ptqs_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// ptqs_cmd_fifo: command queue between intake and execution
// Two-entry queue of classified commands.
// ----------------------------------------------------------------------------
`default_nettype none

module ptqs_cmd_fifo import ptqs_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t wdata,
	input  wire logic pop,
	output logic      full,
	output logic      valid,
	output cmd_t      rdata
);

	localparam int unsigned DEPTH = 2;
	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	cmd_t             entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_pop;

	assign full   = count_q == CNT_W'(DEPTH);
	assign valid  = count_q != '0;
	assign rdata  = entry_q[rd_ptr_q];
	assign do_pop = pop && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + CNT_W'(push) - CNT_W'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= wdata;
	end

endmodule

`default_nettype wire

// ===== sv/ptqs_ring.sv =====
// ----------------------------------------------------------------------------
// ptqs_ring: circular message queue
// Slot memory with read and write pointers and a fill count; drop, push and
// pop apply in that order within one transaction. Head data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ptqs_ring import ptqs_pkg::*; #(
	parameter int unsigned DEPTH  = 8,
	parameter int unsigned DATA_W = 40
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ring_ctl_t         ctl,
	input  wire logic [DATA_W-1:0] wdata,
	output logic [$clog2(DEPTH+1)-1:0] fill,
	output logic                   full,
	output logic                   empty,
	output logic [DATA_W-1:0]      rdata
);

	localparam int unsigned PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned FILL_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [FILL_W-1:0] fill_q;
	logic [PTR_W-1:0]  rd_mid;
	logic [FILL_W-1:0] fill_mid;
	logic [DATA_W-1:0] rdata_q;

	function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] ptr);
		advance = (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + 1'b1;
	endfunction

	assign fill  = fill_q;
	assign full  = fill_q == FILL_W'(DEPTH);
	assign empty = fill_q == '0;
	assign rdata = rdata_q;

	always_comb begin
		rd_mid   = ctl.drop ? advance(rd_ptr_q) : rd_ptr_q;
		fill_mid = fill_q - FILL_W'(ctl.drop);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			fill_q   <= '0;
		end else if (ctl.clear) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			rd_ptr_q <= ctl.pop ? advance(rd_mid) : rd_mid;
			if (ctl.push)
				wr_ptr_q <= advance(wr_ptr_q);
			fill_q <= fill_mid + FILL_W'(ctl.push) - FILL_W'(ctl.pop);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push)
			slot_q[wr_ptr_q] <= wdata;
		rdata_q <= slot_q[rd_mid];
	end

endmodule

`default_nettype wire

// ===== sv/ptqs_back.sv =====
// ----------------------------------------------------------------------------
// ptqs_back: command execution
// Applies drop, push and strict-priority pop to the three rings, then
// registers the result with the popped head.
// ----------------------------------------------------------------------------
`default_nettype none

module ptqs_back import ptqs_pkg::*; #(
	parameter int unsigned RESPONSE_DEPTH = 8,
	parameter int unsigned CONTROL_DEPTH  = 8,
	parameter int unsigned STREAM_DEPTH   = 8,
	parameter int unsigned HANDLE_BITS    = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	input  wire cmd_t cmd,
	output logic      done,
	output res_t      res
);

	localparam int unsigned DATA_W = HANDLE_BITS + 8;
	localparam int unsigned R_FW   = $clog2(RESPONSE_DEPTH + 1);
	localparam int unsigned C_FW   = $clog2(CONTROL_DEPTH + 1);
	localparam int unsigned S_FW   = $clog2(STREAM_DEPTH + 1);
	localparam logic        S_KEEP = STREAM_DEPTH > 1;

	ring_ctl_t         ctl_r, ctl_c, ctl_s;
	logic [R_FW-1:0]   fill_r;
	logic [C_FW-1:0]   fill_c;
	logic [S_FW-1:0]   fill_s;
	logic              full_r, full_c, full_s;
	logic              empty_r, empty_c, empty_s;
	logic [DATA_W-1:0] rdata_r, rdata_c, rdata_s;
	logic [DATA_W-1:0] wdata;

	logic is_enq, is_kick, is_clr, drop, push_ok, do_kick, send, bypass;
	logic ne_mid_s, ne_r, ne_c, ne_s, any_ne, was_empty;
	cls_t sel;

	logic              done_s2;
	logic              status_s2;
	logic              sent_s2;
	cls_t              sel_s2;
	logic              bypass_s2;
	logic [DATA_W-1:0] byp_data_s2;
	logic              dropped_s2;
	logic [DATA_W-1:0] head;

	assign wdata = {HANDLE_BITS'(cmd.handle), cmd.length};

	always_comb begin
		is_enq  = cmd_valid && cmd.op == OP_ENQUEUE;
		is_kick = cmd_valid && cmd.op == OP_KICK;
		is_clr  = cmd_valid && cmd.op == OP_CLEAR;
		drop    = is_enq && cmd.cls == CLS_STREAM && full_s;
		ne_mid_s = drop ? S_KEEP : !empty_s;
		push_ok = is_enq && !cmd.too_long && cmd.cls != CLS_INVALID
			&& !(cmd.cls == CLS_RESPONSE && full_r)
			&& !(cmd.cls == CLS_CONTROL && full_c);
		ne_r    = !empty_r || (push_ok && cmd.cls == CLS_RESPONSE);
		ne_c    = !empty_c || (push_ok && cmd.cls == CLS_CONTROL);
		ne_s    = ne_mid_s || (push_ok && cmd.cls == CLS_STREAM);
		do_kick = is_kick || push_ok;
		any_ne  = 1'b1;
		if (ne_r) begin
			sel       = CLS_RESPONSE;
			was_empty = empty_r;
		end else if (ne_c) begin
			sel       = CLS_CONTROL;
			was_empty = empty_c;
		end else if (ne_s) begin
			sel       = CLS_STREAM;
			was_empty = !ne_mid_s;
		end else begin
			sel       = CLS_INVALID;
			was_empty = 1'b0;
			any_ne    = 1'b0;
		end
		send   = do_kick && any_ne && cmd.sink_ready;
		bypass = push_ok && was_empty;
	end

	always_comb begin
		ctl_r.clear = is_clr;
		ctl_r.drop  = 1'b0;
		ctl_r.push  = push_ok && cmd.cls == CLS_RESPONSE;
		ctl_r.pop   = send && sel == CLS_RESPONSE;
		ctl_c.clear = is_clr;
		ctl_c.drop  = 1'b0;
		ctl_c.push  = push_ok && cmd.cls == CLS_CONTROL;
		ctl_c.pop   = send && sel == CLS_CONTROL;
		ctl_s.clear = is_clr;
		ctl_s.drop  = drop;
		ctl_s.push  = push_ok && cmd.cls == CLS_STREAM;
		ctl_s.pop   = send && sel == CLS_STREAM;
	end

	ptqs_ring #(.DEPTH(RESPONSE_DEPTH), .DATA_W(DATA_W)) u_ring_r (
		.clk(clk), .arst_n(arst_n), .ctl(ctl_r), .wdata(wdata),
		.fill(fill_r), .full(full_r), .empty(empty_r), .rdata(rdata_r)
	);

	ptqs_ring #(.DEPTH(CONTROL_DEPTH), .DATA_W(DATA_W)) u_ring_c (
		.clk(clk), .arst_n(arst_n), .ctl(ctl_c), .wdata(wdata),
		.fill(fill_c), .full(full_c), .empty(empty_c), .rdata(rdata_c)
	);

	ptqs_ring #(.DEPTH(STREAM_DEPTH), .DATA_W(DATA_W)) u_ring_s (
		.clk(clk), .arst_n(arst_n), .ctl(ctl_s), .wdata(wdata),
		.fill(fill_s), .full(full_s), .empty(empty_s), .rdata(rdata_s)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_s2 <= 1'b0;
		else
			done_s2 <= cmd_valid;
	end

	always_ff @(posedge clk) begin
		status_s2   <= is_enq && !push_ok;
		sent_s2     <= send;
		sel_s2      <= sel;
		bypass_s2   <= bypass;
		byp_data_s2 <= wdata;
		dropped_s2  <= drop;
	end

	always_comb begin
		case (sel_s2)
			CLS_RESPONSE: head = rdata_r;
			CLS_CONTROL:  head = rdata_c;
			default:      head = rdata_s;
		endcase
		if (bypass_s2)
			head = byp_data_s2;
	end

	assign done = done_s2;

	always_comb begin
		res.status         = status_s2;
		res.sent_valid     = sent_s2;
		res.sent_class     = sent_s2 ? sel_s2 : '0;
		res.sent_handle    = sent_s2 ? 32'(head[DATA_W-1:8]) : '0;
		res.sent_length    = sent_s2 ? head[7:0] : '0;
		res.stream_dropped = dropped_s2;
		res.response_fill  = 4'(fill_r);
		res.control_fill   = 4'(fill_c);
		res.stream_fill    = 4'(fill_s);
	end

endmodule

`default_nettype wire

// ===== sv/priority_tx_queue_scheduler.sv =====
// ----------------------------------------------------------------------------
// priority_tx_queue_scheduler: strict-priority three-queue transmit scheduler
// Response, control and stream queues served response first.
// ----------------------------------------------------------------------------
// One transaction is taken per clock cycle and its result appears on the
// outputs, marked by done, for exactly one cycle once it has passed the
// command queue and the result registers; results come out in order. The
// rate is set by the execution stage, which retires one command per cycle
// from the two-entry command queue; since results leave without back-pressure
// that queue never holds more than one command, so busy stays low.
`default_nettype none

module priority_tx_queue_scheduler import ptqs_pkg::*; #(
	parameter int unsigned RESPONSE_DEPTH    = 8,
	parameter int unsigned CONTROL_DEPTH     = 8,
	parameter int unsigned STREAM_DEPTH      = 8,
	parameter int unsigned MAX_MESSAGE_BYTES = 64,
	parameter int unsigned HANDLE_BITS       = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  opcode,
	input  wire logic [1:0]  msg_class,
	input  wire logic [31:0] message_handle,
	input  wire logic [7:0]  message_length,
	input  wire logic        sink_ready,
	output logic             done,
	output logic             status,
	output logic             sent_valid,
	output logic [1:0]       sent_class,
	output logic [31:0]      sent_handle,
	output logic [7:0]       sent_length,
	output logic             stream_dropped,
	output logic [3:0]       response_fill,
	output logic [3:0]       control_fill,
	output logic [3:0]       stream_fill
);

	logic fifo_full;
	logic fifo_push;
	logic fifo_valid;
	cmd_t front_cmd;
	cmd_t back_cmd;
	res_t res;

	ptqs_front #(.MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)) u_front (
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.msg_class(msg_class),
		.message_handle(message_handle),
		.message_length(message_length),
		.sink_ready(sink_ready),
		.fifo_full(fifo_full),
		.push(fifo_push),
		.cmd(front_cmd)
	);

	ptqs_cmd_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(fifo_push),
		.wdata(front_cmd),
		.pop(fifo_valid),
		.full(fifo_full),
		.valid(fifo_valid),
		.rdata(back_cmd)
	);

	ptqs_back #(
		.RESPONSE_DEPTH(RESPONSE_DEPTH),
		.CONTROL_DEPTH(CONTROL_DEPTH),
		.STREAM_DEPTH(STREAM_DEPTH),
		.HANDLE_BITS(HANDLE_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(fifo_valid),
		.cmd(back_cmd),
		.done(done),
		.res(res)
	);

	assign status         = res.status;
	assign sent_valid     = res.sent_valid;
	assign sent_class     = res.sent_class;
	assign sent_handle    = res.sent_handle;
	assign sent_length    = res.sent_length;
	assign stream_dropped = res.stream_dropped;
	assign response_fill  = res.response_fill;
	assign control_fill   = res.control_fill;
	assign stream_fill    = res.stream_fill;

endmodule

`default_nettype wire

// ===== sv/ptqs_checker.sv =====
// ----------------------------------------------------------------------------
// ptqs_checker: port-level checks for the transmit scheduler
// Result timing, idle result fields, rejects and fill level movement.
// ----------------------------------------------------------------------------
`default_nettype none

module ptqs_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic [1:0]  opcode,
	input wire logic [1:0]  msg_class,
	input wire logic [31:0] message_handle,
	input wire logic [7:0]  message_length,
	input wire logic        sink_ready,
	input wire logic        done,
	input wire logic        status,
	input wire logic        sent_valid,
	input wire logic [1:0]  sent_class,
	input wire logic [31:0] sent_handle,
	input wire logic [7:0]  sent_length,
	input wire logic        stream_dropped,
	input wire logic [3:0]  response_fill,
	input wire logic [3:0]  control_fill,
	input wire logic [3:0]  stream_fill
);

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> ##1 done)
		else $error("accepted transaction gave no result");

	a_no_idle_send: assert property (@(posedge clk) disable iff (!arst_n)
		done && !sent_valid |-> sent_class == 2'd0 && sent_handle == 32'd0
			&& sent_length == 8'd0)
		else $error("sent fields not clear without a send");

	a_reject_no_send: assert property (@(posedge clk) disable iff (!arst_n)
		done && status |-> !sent_valid)
		else $error("rejected enqueue sent a message");

	a_fill_moves_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		!($stable(response_fill) && $stable(control_fill) && $stable(stream_fill))
			|-> done)
		else $error("fill level moved without a result");

endmodule

bind priority_tx_queue_scheduler ptqs_checker u_ptqs_checker (.*);

`default_nettype wire

// ===== dv/priority_tx_queue_scheduler_tb.sv =====
// ----------------------------------------------------------------------------
// priority_tx_queue_scheduler_tb: self-checking bench for the TX queue scheduler
// A directed table covers reset state, extremes, rejects and stream drops.
// Random traffic follows in phases of sink readiness. Every result is checked
// field by field against a typed row's record or a 3-ring priority model.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module priority_tx_queue_scheduler_tb;
	import ptqs_pkg::*;

	localparam int unsigned RING_DEPTH   = 8;
	localparam int unsigned MAX_BYTES    = 64;
	localparam int unsigned RANDOM_ITEMS = 1550;
	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned DRAIN_CYCLES = 8;

	typedef struct {
		op_t         op;
		cls_t        cls;
		logic [31:0] handle;
		logic [7:0]  length;
		logic        ready;
		bit          typed;
		res_t        want;
	} stim_row_t;

	logic        clk            = 1'b0;
	logic        arst_n         = 1'b0;
	logic        start          = 1'b0;
	op_t         opcode         = OP_NOP;
	cls_t        msg_class      = CLS_RESPONSE;
	logic [31:0] message_handle = '0;
	logic [7:0]  message_length = '0;
	logic        sink_ready     = 1'b0;
	logic        busy;
	logic        done;
	logic        status;
	logic        sent_valid;
	logic [1:0]  sent_class;
	logic [31:0] sent_handle;
	logic [7:0]  sent_length;
	logic        stream_dropped;
	logic [3:0]  response_fill;
	logic [3:0]  control_fill;
	logic [3:0]  stream_fill;

	// ring model state
	logic [31:0] ring_handle [3][RING_DEPTH];
	logic [7:0]  ring_length [3][RING_DEPTH];
	int unsigned rd_ptr [3];
	int unsigned wr_ptr [3];
	int unsigned fill   [3];

	res_t        pending_outcomes [$];
	stim_row_t   directed_rows [$];
	int unsigned fail_count   = 0;
	int unsigned burst_left   = 0;
	int unsigned cycle_count  = 0;
	int unsigned n_items      = 0;
	int unsigned n_sent       = 0;
	int unsigned n_rejected   = 0;
	int unsigned n_dropped    = 0;
	int unsigned n_results    = 0;

	priority_tx_queue_scheduler #(
		.RESPONSE_DEPTH   (RING_DEPTH),
		.CONTROL_DEPTH    (RING_DEPTH),
		.STREAM_DEPTH     (RING_DEPTH),
		.MAX_MESSAGE_BYTES(MAX_BYTES),
		.HANDLE_BITS      (32)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.opcode        (opcode),
		.msg_class     (msg_class),
		.message_handle(message_handle),
		.message_length(message_length),
		.sink_ready    (sink_ready),
		.done          (done),
		.status        (status),
		.sent_valid    (sent_valid),
		.sent_class    (sent_class),
		.sent_handle   (sent_handle),
		.sent_length   (sent_length),
		.stream_dropped(stream_dropped),
		.response_fill (response_fill),
		.control_fill  (control_fill),
		.stream_fill   (stream_fill)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic void advance_head(int unsigned q);
		if (fill[q] != 0) begin
			rd_ptr[q] = (rd_ptr[q] + 1 >= RING_DEPTH) ? 0 : rd_ptr[q] + 1;
			fill[q]--;
		end
	endfunction

	// offer the highest-priority head; pop it only when the sink takes it
	function automatic void offer_head(logic ready, inout res_t r);
		for (int q = 0; q < 3; q++) begin
			if (fill[q] != 0) begin
				if (ready) begin
					r.sent_valid  = 1'b1;
					r.sent_class  = q[1:0];
					r.sent_handle = ring_handle[q][rd_ptr[q]];
					r.sent_length = ring_length[q][rd_ptr[q]];
					advance_head(q);
				end
				return;
			end
		end
	endfunction

	function automatic res_t schedule_outcome(op_t op, cls_t cls, logic [31:0] handle,
			logic [7:0] len, logic ready);
		res_t r;
		bit   queued;
		int   q;
		r      = '0;
		queued = 1'b0;
		q      = int'(cls);
		case (op)
			OP_ENQUEUE: begin
				if (cls == CLS_STREAM && fill[2] >= RING_DEPTH) begin
					advance_head(2);
					r.stream_dropped = 1'b1;
				end
				if (cls != CLS_INVALID && fill[q] < RING_DEPTH && len <= MAX_BYTES) begin
					ring_handle[q][wr_ptr[q]] = handle;
					ring_length[q][wr_ptr[q]] = len;
					wr_ptr[q] = (wr_ptr[q] + 1 >= RING_DEPTH) ? 0 : wr_ptr[q] + 1;
					fill[q]++;
					queued = 1'b1;
				end
				if (queued)
					offer_head(ready, r);
				else
					r.status = 1'b1;
			end
			OP_KICK: offer_head(ready, r);
			OP_CLEAR: begin
				for (int i = 0; i < 3; i++) begin
					rd_ptr[i] = 0;
					wr_ptr[i] = 0;
					fill[i]   = 0;
				end
			end
			default: ;
		endcase
		r.response_fill = fill[0][3:0];
		r.control_fill  = fill[1][3:0];
		r.stream_fill   = fill[2][3:0];
		return r;
	endfunction

	function automatic void add_row(op_t op, cls_t cls, logic [31:0] handle, logic [7:0] len,
			logic ready, bit typed = 1'b0, res_t want = '0);
		stim_row_t row;
		row.op     = op;
		row.cls    = cls;
		row.handle = handle;
		row.length = len;
		row.ready  = ready;
		row.typed  = typed;
		row.want   = want;
		directed_rows.push_back(row);
	endfunction

	// present one transaction, hold it until taken, then log what it should yield
	task automatic issue_item(stim_row_t row);
		int unsigned gap;
		res_t        predicted;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		start          <= 1'b1;
		opcode         <= row.op;
		msg_class      <= row.cls;
		message_handle <= row.handle;
		message_length <= row.length;
		sink_ready     <= row.ready;
		do @(posedge clk); while (busy !== 1'b0);
		predicted = schedule_outcome(row.op, row.cls, row.handle, row.length, row.ready);
		pending_outcomes.push_back(row.typed ? row.want : predicted);
		n_items++;
		n_sent     += predicted.sent_valid;
		n_rejected += predicted.status;
		n_dropped  += predicted.stream_dropped;
	endtask

	task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		res_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_outcomes.size() == 0) begin
				$display("%0t ns: unexpected result transaction, expected none, got one",
					$time);
				fail_count++;
			end else begin
				want = pending_outcomes.pop_front();
				n_results++;
				compare_field("status",         want.status,         status);
				compare_field("sent_valid",     want.sent_valid,     sent_valid);
				compare_field("sent_class",     want.sent_class,     sent_class);
				compare_field("sent_handle",    want.sent_handle,    sent_handle);
				compare_field("sent_length",    want.sent_length,    sent_length);
				compare_field("stream_dropped", want.stream_dropped, stream_dropped);
				compare_field("response_fill",  want.response_fill,  response_fill);
				compare_field("control_fill",   want.control_fill,   control_fill);
				compare_field("stream_fill",    want.stream_fill,    stream_fill);
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("** priority_tx_queue_scheduler: FAILED **");
		$finish;
	end

	initial begin
		stim_row_t   row;
		int unsigned ready_pct;
		int unsigned roll;
		int unsigned active;
		for (int q = 0; q < 3; q++) begin
			rd_ptr[q] = 0;
			wr_ptr[q] = 0;
			fill[q]   = 0;
		end

		// directed table: status, sent_valid, class, handle, length, drop, fills
		add_row(OP_KICK,    CLS_RESPONSE, 32'h0,        8'd0,   1'b1, 1'b1,
			res_t'{1'b0, 1'b0, 2'd0, 32'h0, 8'd0, 1'b0, 4'd0, 4'd0, 4'd0});
		add_row(OP_CLEAR,   CLS_CONTROL,  32'h0,        8'd0,   1'b1, 1'b1,
			res_t'{1'b0, 1'b0, 2'd0, 32'h0, 8'd0, 1'b0, 4'd0, 4'd0, 4'd0});
		add_row(OP_NOP,     CLS_STREAM,   32'hFFFFFFFF, 8'd255, 1'b1, 1'b1,
			res_t'{1'b0, 1'b0, 2'd0, 32'h0, 8'd0, 1'b0, 4'd0, 4'd0, 4'd0});
		add_row(OP_ENQUEUE, CLS_INVALID,  32'hA5A5A5A5, 8'd10,  1'b1, 1'b1,
			res_t'{1'b1, 1'b0, 2'd0, 32'h0, 8'd0, 1'b0, 4'd0, 4'd0, 4'd0});
		add_row(OP_ENQUEUE, CLS_RESPONSE, 32'h1,        8'd65,  1'b1, 1'b1,
			res_t'{1'b1, 1'b0, 2'd0, 32'h0, 8'd0, 1'b0, 4'd0, 4'd0, 4'd0});
		add_row(OP_ENQUEUE, CLS_RESPONSE, 32'h1,        8'd64,  1'b0, 1'b1,
			res_t'{1'b0, 1'b0, 2'd0, 32'h0, 8'd0, 1'b0, 4'd1, 4'd0, 4'd0});
		add_row(OP_ENQUEUE, CLS_CONTROL,  32'hFFFFFFFF, 8'd0,   1'b0, 1'b1,
			res_t'{1'b0, 1'b0, 2'd0, 32'h0, 8'd0, 1'b0, 4'd1, 4'd1, 4'd0});
		add_row(OP_ENQUEUE, CLS_STREAM,   32'h5A5A5A5A, 8'd1,   1'b0);
		repeat (4) add_row(OP_KICK, CLS_RESPONSE, 32'h0, 8'd0, 1'b1);
		for (int i = 0; i < RING_DEPTH; i++)
			add_row(OP_ENQUEUE, CLS_STREAM, 32'h1000 + i, 8'(8 * i), 1'b0);
		add_row(OP_ENQUEUE, CLS_STREAM,   32'hDEADBEEF, 8'd255, 1'b1);
		add_row(OP_ENQUEUE, CLS_STREAM,   32'h0BADF00D, 8'd64,  1'b0);
		add_row(OP_ENQUEUE, CLS_STREAM,   32'h12345678, 8'd2,   1'b1);
		add_row(OP_ENQUEUE, CLS_RESPONSE, 32'h87654321, 8'd255, 1'b1);
		add_row(OP_CLEAR,   CLS_RESPONSE, 32'h0,        8'd0,   1'b0);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			issue_item(directed_rows[i]);

		// random traffic in phases of sink readiness
		active    = 0;
		ready_pct = 50;
		while (active < RANDOM_ITEMS) begin
			if (active % 150 == 0) begin
				case ($urandom_range(0, 2))
					0: ready_pct = 5;
					1: ready_pct = 45;
					default: ready_pct = 95;
				endcase
			end
			roll = $urandom_range(0, 99);
			row.op = (roll < 60) ? OP_ENQUEUE : (roll < 88) ? OP_KICK :
				(roll < 91) ? OP_CLEAR : OP_NOP;
			roll = $urandom_range(0, 99);
			row.cls = (roll < 25) ? CLS_RESPONSE : (roll < 50) ? CLS_CONTROL :
				(roll < 90) ? CLS_STREAM : CLS_INVALID;
			row.handle = $urandom;
			roll = $urandom_range(0, 99);
			row.length = (roll < 80) ? 8'($urandom_range(0, MAX_BYTES)) :
				(roll < 90) ? 8'($urandom_range(MAX_BYTES, MAX_BYTES + 1)) :
				8'($urandom_range(0, 255));
			row.ready = ($urandom_range(0, 99) < ready_pct);
			row.typed = 1'b0;
			row.want  = '0;
			issue_item(row);
			active++;
		end
		start <= 1'b0;

		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d transactions, %0d results checked: %0d sent, %0d rejected,",
			n_items, n_results, n_sent, n_rejected);
		$display("%0d stream drops, over directed extremes and random readiness phases.",
			n_dropped);
		if (fail_count == 0)
			$display("** priority_tx_queue_scheduler: PASSED **");
		else
			$display("** priority_tx_queue_scheduler: FAILED **");
		$finish;
	end

endmodule

// ===== files.f =====
sv/ptqs_pkg.sv
sv/ptqs_front.sv
sv/ptqs_cmd_fifo.sv
sv/ptqs_ring.sv
sv/ptqs_back.sv
sv/priority_tx_queue_scheduler.sv
sv/ptqs_checker.sv
dv/priority_tx_queue_scheduler_tb.sv
